// ===== sv/ecnt_pkg.sv =====
package ecnt_pkg;

   // Build-time sizing of the block.
   localparam int Channels  = 4;
   localparam int PortWidth = 16;

   // Fixed field widths.
   localparam int SampleW   = 16;
   localparam int CountW    = 32;
   localparam int OpW       = 3;
   localparam int ChanW     = 4;
   localparam int ModeW     = 2;

   // Channels that own a slice of the mask and mode registers.
   localparam int RegChannels = 4;

   // Index width into the per-channel state.
   localparam int ChanIdxW = (Channels > 1) ? $clog2(Channels) : 1;

   // Port bits that are visible to the channels.
   localparam int SeenW = (PortWidth < SampleW) ? PortWidth : SampleW;
   localparam logic [SampleW-1:0] PortMask = SampleW'((33'd1 << SeenW) - 33'd1);

   // Operation codes.
   localparam logic [OpW-1:0] OpSample    = 3'd0;
   localparam logic [OpW-1:0] OpRead      = 3'd1;
   localparam logic [OpW-1:0] OpReadClear = 3'd2;
   localparam logic [OpW-1:0] OpClear     = 3'd3;
   localparam logic [OpW-1:0] OpArm       = 3'd4;

   // Edge modes.
   localparam logic [ModeW-1:0] ModeRising  = 2'd0;
   localparam logic [ModeW-1:0] ModeFalling = 2'd1;
   localparam logic [ModeW-1:0] ModeBoth    = 2'd2;
   localparam logic [ModeW-1:0] ModeNone    = 2'd3;

   // Control register indexes.
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CsrChannelMasks  = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrEdgeModes     = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrActiveChannels = 2'd2;

   // Control register contents.
   typedef struct packed {
      logic [63:0] channel_masks;
      logic [7:0]  edge_modes;
      logic [2:0]  active_channels;
   } ecnt_cfg_type;

   // One request word as seen by the counter core.
   typedef struct packed {
      logic [OpW-1:0]     operation;
      logic [ChanW-1:0]   channel;
      logic [SampleW-1:0] port_sample;
   } ecnt_req_type;

endpackage

// ===== sv/ecnt_core.sv =====
module ecnt_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  ecnt_pkg::ecnt_cfg_type        cfg,
   input  ecnt_pkg::ecnt_req_type        req,
   output logic [ecnt_pkg::CountW-1:0]   edge_count,
   output logic                          channel_ok
);

   logic [ecnt_pkg::CountW-1:0] counts_ff [ecnt_pkg::Channels];
   logic [ecnt_pkg::CountW-1:0] counts_in [ecnt_pkg::Channels];
   logic [ecnt_pkg::Channels-1:0] last_ff;
   logic [ecnt_pkg::Channels-1:0] last_in;

   logic [ecnt_pkg::SampleW-1:0] port_seen;
   logic                         is_sample;
   logic                         chan_valid;
   logic [ecnt_pkg::ChanIdxW-1:0] chan_idx;

   // Decode the request word.
   assign port_seen  = req.port_sample & ecnt_pkg::PortMask;
   assign is_sample  = (req.operation == ecnt_pkg::OpSample);
   assign chan_valid = ({1'b0, req.channel} < 5'(ecnt_pkg::Channels));
   assign chan_idx   = ecnt_pkg::ChanIdxW'(req.channel);
   assign channel_ok = chan_valid && !is_sample && (req.operation <= ecnt_pkg::OpArm);

   // Addressed count, taken before any clear.
   assign edge_count = channel_ok ? counts_ff[chan_idx] : '0;

   // Per-channel edge detection and next state.
   for (genvar k = 0; k < ecnt_pkg::Channels; k++) begin : g_chan
      logic [ecnt_pkg::SampleW-1:0] pin_mask;
      logic [ecnt_pkg::ModeW-1:0]   mode;
      logic                         level_now;
      logic                         active;
      logic                         changed;
      logic                         counted;
      logic                         hit;

      if (k < ecnt_pkg::RegChannels) begin : g_reg
         assign pin_mask = cfg.channel_masks[ecnt_pkg::SampleW*k +: ecnt_pkg::SampleW];
         assign mode     = cfg.edge_modes[ecnt_pkg::ModeW*k +: ecnt_pkg::ModeW];
      end else begin : g_none
         assign pin_mask = '0;
         assign mode     = ecnt_pkg::ModeNone;
      end

      assign level_now = |(port_seen & pin_mask);
      assign active    = (32'(cfg.active_channels) > k);
      assign changed   = is_sample && active && (level_now != last_ff[k]);
      assign counted   = (mode == ecnt_pkg::ModeBoth)
                      || ((mode == ecnt_pkg::ModeRising) && level_now)
                      || ((mode == ecnt_pkg::ModeFalling) && !level_now);
      assign hit       = channel_ok && (32'(req.channel) == k);

      always_comb begin
         counts_in[k] = counts_ff[k];
         last_in[k]   = last_ff[k];
         if (changed) begin
            last_in[k] = level_now;
            if (counted) begin
               counts_in[k] = counts_ff[k] + ecnt_pkg::CountW'(1);
            end
         end else if (hit) begin
            if (req.operation == ecnt_pkg::OpReadClear
                || req.operation == ecnt_pkg::OpClear) begin
               counts_in[k] = '0;
            end else if (req.operation == ecnt_pkg::OpArm) begin
               counts_in[k] = '0;
               last_in[k]   = level_now;
            end
         end
      end
   end

   // Channel state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ecnt_pkg::Channels; k++) begin
            counts_ff[k] <= '0;
         end
         last_ff <= '0;
      end else if (update) begin
         for (int k = 0; k < ecnt_pkg::Channels; k++) begin
            counts_ff[k] <= counts_in[k];
         end
         last_ff <= last_in;
      end
   end

endmodule

// ===== sv/multi_channel_edge_counter.sv =====
// Multi-channel edge counter. Each request word carries an operation, a channel
// number and a 16-bit port sample. A sample operation checks every active
// channel (the level is the OR of its masked pins) against its last level and
// bumps its 32-bit wrapping count when the edge mode accepts the change; read,
// read-and-clear, clear and arm address one channel and return its count as it
// was before the word. Every request gives exactly one response word. Requests
// go through an input register and the channel logic into a response register,
// so one word is taken every clock while the response side keeps up. The
// control registers are written through the csr port, which is always ready,
// and must only be written while no word is in flight.
module multi_channel_edge_counter (
   input  logic                            clock,
   input  logic                            reset,
   // Request: operation [2:0], channel [6:3], port_sample [22:7], zero pad [23].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,
   // Response: edge_count [31:0], channel_ok [32], zero pad [39:33].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [39:0]                     rsp_tdata,
   // Control register writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ecnt_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [63:0]                     csr_data
);

   ecnt_pkg::ecnt_cfg_type cfg_ff;
   ecnt_pkg::ecnt_req_type stage_ff;
   logic                   stage_valid_ff;
   logic                   rsp_valid_ff;
   logic [ecnt_pkg::CountW-1:0] rsp_count_ff;
   logic                   rsp_ok_ff;

   logic                   advance;
   logic [ecnt_pkg::CountW-1:0] core_count;
   logic                   core_ok;

   // Pipeline flow: the staged word moves on when the response register frees up.
   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ecnt_pkg::CsrChannelMasks:   cfg_ff.channel_masks   <= csr_data;
            ecnt_pkg::CsrEdgeModes:      cfg_ff.edge_modes      <= csr_data[7:0];
            ecnt_pkg::CsrActiveChannels: cfg_ff.active_channels <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // Valid flags of the input and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_tready) begin
            stage_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff.operation   <= req_tdata[2:0];
         stage_ff.channel     <= req_tdata[6:3];
         stage_ff.port_sample <= req_tdata[22:7];
      end
   end

   ecnt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .cfg        (cfg_ff),
      .req        (stage_ff),
      .edge_count (core_count),
      .channel_ok (core_ok)
   );

   // Response word register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_count_ff <= core_count;
         rsp_ok_ff    <= core_ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff, rsp_count_ff};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Operation codes the block does not define; they must leave all state alone.
   localparam logic [ecnt_pkg::OpW-1:0] OpSpare5 = 3'd5;
   localparam logic [ecnt_pkg::OpW-1:0] OpSpare6 = 3'd6;
   localparam logic [ecnt_pkg::OpW-1:0] OpSpare7 = 3'd7;

   // Register index with no register behind it.
   localparam logic [ecnt_pkg::CsrIdxW-1:0] CsrSpare = 2'd3;

   // The pipeline has an input register and a response register; the drain wait adds settle time beyond them.
   localparam int DrainCycles = 6;
   localparam int HoldCycles  = 150;
   localparam int CycleLimit  = 200000;

   typedef struct packed {
      logic [ecnt_pkg::OpW-1:0]     op;
      logic [ecnt_pkg::ChanW-1:0]   chan;
      logic [ecnt_pkg::SampleW-1:0] port;
   } port_word_type;

   typedef struct packed {
      logic [ecnt_pkg::CountW-1:0] count;
      logic                        ok;
   } count_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [ecnt_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   // Predicted register contents and per-channel state.
   logic [63:0]                 pin_masks = '0;
   logic [7:0]                  mode_bits = '0;
   logic [2:0]                  active_count = '0;
   logic [ecnt_pkg::CountW-1:0] edge_tally [ecnt_pkg::Channels];
   logic                        held_level [ecnt_pkg::Channels];

   count_reply_type due_counts [$];

   int  send_idle_pct = 0;
   int  rsp_stall_pct = 0;
   bit  rsp_hold = 1'b0;
   int  mismatches = 0;
   int  cycle_count = 0;

   multi_channel_edge_counter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Run length guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver side: random stalls, or a forced hold-off while rsp_hold is set.
   always @(negedge clock) begin
      if (rsp_hold)
         rsp_tready <= 1'b0;
      else if (rsp_stall_pct == 0)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Compare every accepted response word with the oldest predicted count.
   always @(posedge clock) begin
      count_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected response word %h", rsp_tdata));
         end else begin
            want = due_counts.pop_front();
            if (rsp_tdata[31:0] !== want.count)
               report_mismatch($sformatf("edge_count %h, predicted %h",
                                         rsp_tdata[31:0], want.count));
            if (rsp_tdata[32] !== want.ok)
               report_mismatch($sformatf("channel_ok %b, predicted %b",
                                         rsp_tdata[32], want.ok));
         end
      end
   end

   // Level of channel k for a port value: any masked pin high.
   function automatic logic chan_level(input int k,
                                       input logic [ecnt_pkg::SampleW-1:0] seen);
      logic [ecnt_pkg::SampleW-1:0] mask;
      mask = (k < ecnt_pkg::RegChannels) ? pin_masks[16*k +: 16] : '0;
      return |(seen & mask);
   endfunction

   // Advance the predicted counters by one request word and give its response.
   function automatic count_reply_type next_count_reply(input port_word_type w);
      count_reply_type              r;
      logic [ecnt_pkg::SampleW-1:0] seen;
      logic [ecnt_pkg::ModeW-1:0]   mode;
      logic                         now;
      int                           n;
      int                           k;
      r.count = '0;
      r.ok = 1'b0;
      seen = w.port & ecnt_pkg::PortMask;
      if (w.op == ecnt_pkg::OpSample) begin
         n = (active_count > ecnt_pkg::Channels) ? ecnt_pkg::Channels
                                                 : int'(active_count);
         for (k = 0; k < n; k++) begin
            now = chan_level(k, seen);
            if (now != held_level[k]) begin
               mode = (k < ecnt_pkg::RegChannels) ? mode_bits[2*k +: 2]
                                                  : ecnt_pkg::ModeNone;
               if (mode == ecnt_pkg::ModeBoth ||
                   (mode == ecnt_pkg::ModeRising && now) ||
                   (mode == ecnt_pkg::ModeFalling && !now))
                  edge_tally[k] = edge_tally[k] + 1'b1;
               held_level[k] = now;
            end
         end
      end else if (w.op <= ecnt_pkg::OpArm && w.chan < ecnt_pkg::Channels) begin
         r.ok = 1'b1;
         r.count = edge_tally[w.chan];
         if (w.op == ecnt_pkg::OpReadClear || w.op == ecnt_pkg::OpClear) begin
            edge_tally[w.chan] = '0;
         end else if (w.op == ecnt_pkg::OpArm) begin
            edge_tally[w.chan] = '0;
            held_level[w.chan] = chan_level(int'(w.chan), seen);
         end
      end
      return r;
   endfunction

   // Offer one request word, with random idle cycles ahead of it.
   task automatic send_word(input logic [ecnt_pkg::OpW-1:0] op,
                            input logic [ecnt_pkg::ChanW-1:0] chan,
                            input logic [ecnt_pkg::SampleW-1:0] port);
      port_word_type w;
      w.op = op;
      w.chan = chan;
      w.port = port;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {1'b0, w.port, w.chan, w.op};
      do @(posedge clock); while (!req_tready);
      due_counts.push_back(next_count_reply(w));
      @(negedge clock);
   endtask

   // Stop offering words until every predicted response has come back.
   task automatic wait_drain();
      req_tvalid = 1'b0;
      while (due_counts.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ecnt_pkg::CsrIdxW-1:0] idx,
                            input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ecnt_pkg::CsrChannelMasks:   pin_masks = value;
         ecnt_pkg::CsrEdgeModes:      mode_bits = value[7:0];
         ecnt_pkg::CsrActiveChannels: active_count = value[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // New settings for all three registers; extremes turn up often.
   task automatic load_random_settings();
      logic [63:0] masks;
      int          k;
      for (k = 0; k < ecnt_pkg::RegChannels; k++) begin
         case ($urandom_range(0, 4))
            0:       masks[16*k +: 16] = 16'h0000;
            1:       masks[16*k +: 16] = 16'hFFFF;
            default: masks[16*k +: 16] = 16'($urandom & $urandom & $urandom);
         endcase
      end
      write_csr(ecnt_pkg::CsrChannelMasks, masks);
      case ($urandom_range(0, 5))
         0:       write_csr(ecnt_pkg::CsrEdgeModes, 64'h00);
         1:       write_csr(ecnt_pkg::CsrEdgeModes, 64'hFF);
         default: write_csr(ecnt_pkg::CsrEdgeModes, 64'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 2) == 0)
         write_csr(ecnt_pkg::CsrActiveChannels, 64'($urandom_range(0, 7)));
      else
         write_csr(ecnt_pkg::CsrActiveChannels, 64'(ecnt_pkg::Channels));
   endtask

   // Mostly samples with sparse port values so channel levels really toggle.
   function automatic port_word_type random_word();
      port_word_type w;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      w.op = ecnt_pkg::OpSample;
      else if (pick < 65) w.op = ecnt_pkg::OpRead;
      else if (pick < 73) w.op = ecnt_pkg::OpReadClear;
      else if (pick < 80) w.op = ecnt_pkg::OpClear;
      else if (pick < 93) w.op = ecnt_pkg::OpArm;
      else                w.op = ecnt_pkg::OpW'($urandom_range(5, 7));
      if ($urandom_range(0, 99) < 85)
         w.chan = ecnt_pkg::ChanW'($urandom_range(0, ecnt_pkg::Channels - 1));
      else
         w.chan = ecnt_pkg::ChanW'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
         0:       w.port = 16'h0000;
         1:       w.port = 16'h0001 << $urandom_range(0, 15);
         2:       w.port = 16'hFFFF;
         3:       w.port = 16'($urandom & $urandom);
         default: w.port = 16'($urandom);
      endcase
      return w;
   endfunction

   // Hand-picked words: every operation, invalid channels, spare codes, saturation.
   task automatic test_directed();
      // Reset state: nothing active, counts zero.
      send_word(ecnt_pkg::OpSample, 4'd0, 16'hFFFF);
      send_word(ecnt_pkg::OpRead, 4'd0, 16'h0000);
      wait_drain();
      write_csr(ecnt_pkg::CsrChannelMasks, {16'hFFFF, 16'h00F0, 16'h0002, 16'h0001});
      write_csr(ecnt_pkg::CsrEdgeModes,
                64'({ecnt_pkg::ModeNone, ecnt_pkg::ModeBoth,
                     ecnt_pkg::ModeFalling, ecnt_pkg::ModeRising}));
      // Active count beyond the channel count saturates.
      write_csr(ecnt_pkg::CsrActiveChannels, 64'd7);
      write_csr(CsrSpare, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'hFFFF);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0000);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'hFFFF);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0010);
      send_word(ecnt_pkg::OpRead, 4'd0, 16'h0000);
      send_word(ecnt_pkg::OpRead, 4'd1, 16'h0000);
      send_word(ecnt_pkg::OpReadClear, 4'd2, 16'h0000);
      send_word(ecnt_pkg::OpRead, 4'd2, 16'h0000);
      send_word(ecnt_pkg::OpClear, 4'd0, 16'h0000);
      send_word(ecnt_pkg::OpArm, 4'd1, 16'h0000);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0002);
      send_word(ecnt_pkg::OpRead, 4'd1, 16'h0000);
      send_word(ecnt_pkg::OpRead, 4'd3, 16'hFFFF);
      // Channel numbers at or beyond the channel count.
      send_word(ecnt_pkg::OpRead, 4'd4, 16'h0000);
      send_word(ecnt_pkg::OpReadClear, 4'd15, 16'hFFFF);
      send_word(ecnt_pkg::OpClear, 4'd8, 16'h0000);
      send_word(ecnt_pkg::OpArm, 4'd12, 16'hFFFF);
      // Undefined operation codes.
      send_word(OpSpare5, 4'd0, 16'hFFFF);
      send_word(OpSpare6, 4'd1, 16'h0000);
      send_word(OpSpare7, 4'd2, 16'hFFFF);
      wait_drain();
      // Arming a channel outside the active range still captures and clears.
      write_csr(ecnt_pkg::CsrActiveChannels, 64'd1);
      send_word(ecnt_pkg::OpArm, 4'd3, 16'h8000);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0000);
      send_word(ecnt_pkg::OpRead, 4'd3, 16'h0000);
      wait_drain();
   endtask

   // Register extremes: all pins in every mask, then no pins and no channels.
   task automatic test_extreme_settings();
      int k;
      write_csr(ecnt_pkg::CsrChannelMasks, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(ecnt_pkg::CsrEdgeModes,
                64'({ecnt_pkg::ModeBoth, ecnt_pkg::ModeBoth,
                     ecnt_pkg::ModeBoth, ecnt_pkg::ModeBoth}));
      write_csr(ecnt_pkg::CsrActiveChannels, 64'(ecnt_pkg::Channels));
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0000);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'hFFFF);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'h0000);
      for (k = 0; k < ecnt_pkg::Channels; k++)
         send_word(ecnt_pkg::OpRead, ecnt_pkg::ChanW'(k), 16'h0000);
      wait_drain();
      write_csr(ecnt_pkg::CsrChannelMasks, 64'h0);
      write_csr(ecnt_pkg::CsrEdgeModes, 64'hFF);
      write_csr(ecnt_pkg::CsrActiveChannels, 64'd0);
      send_word(ecnt_pkg::OpSample, 4'd0, 16'hFFFF);
      send_word(ecnt_pkg::OpRead, 4'd0, 16'h0000);
      wait_drain();
   endtask

   // Random words in segments, each segment under fresh settings.
   task automatic test_random(input int words, input int idle_pct, input int stall_pct);
      port_word_type w;
      int            i;
      wait_drain();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < words; i++) begin
         if (i % 85 == 0) begin
            wait_drain();
            load_random_settings();
         end
         w = random_word();
         send_word(w.op, w.chan, w.port);
      end
      wait_drain();
   endtask

   // Long receiver hold-off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      port_word_type w;
      int            i;
      wait_drain();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_random_settings();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HoldCycles) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      for (i = 0; i < 60; i++) begin
         w = random_word();
         send_word(w.op, w.chan, w.port);
      end
      wait_drain();
   endtask

   initial begin
      int k;
      for (k = 0; k < ecnt_pkg::Channels; k++) begin
         edge_tally[k] = '0;
         held_level[k] = 1'b0;
      end
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_directed();
      test_extreme_settings();
      test_random(340, 0, 0);
      test_random(340, 81, 0);
      test_random(340, 0, 81);
      test_random(340, 22, 22);
      test_backpressure();
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ecnt_pkg.sv
sv/ecnt_core.sv
sv/multi_channel_edge_counter.sv
tb/sv/testbench.sv
